### rtl/core/restoring_unsigned_divider_macros.svh
// Assertion macros shared by the divider's checker.
// Needs nothing else; include by bare file name.
`ifndef RESTORING_UNSIGNED_DIVIDER_MACROS_SVH
`define RESTORING_UNSIGNED_DIVIDER_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define RUD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("divider check failed");

// Next-cycle implication, checked while reset is released.
`define RUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("divider check failed");

`endif

### rtl/core/rud_pkg.sv
// Shared types for the restoring unsigned divider.
// No dependencies.
package rud_pkg;

	// Control flags that travel with each item from cell to cell.
	typedef struct packed {
		logic valid;
		logic dividend_zero;
		logic divisor_zero;
	} rud_ctrl_t;

endpackage

### rtl/core/rud_cell.sv
// One restoring division step with its pipeline register.
// Depends on rud_pkg for the control struct.
module rud_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  rud_pkg::rud_ctrl_t      ctrl_in,
	input  logic [DATA_WIDTH-1:0]   rem_in,
	input  logic [DATA_WIDTH-1:0]   dq_in,
	input  logic [DATA_WIDTH-1:0]   div_in,
	output rud_pkg::rud_ctrl_t      ctrl_out,
	output logic [DATA_WIDTH-1:0]   rem_out,
	output logic [DATA_WIDTH-1:0]   dq_out,
	output logic [DATA_WIDTH-1:0]   div_out
);
	import rud_pkg::*;

	logic [DATA_WIDTH:0]   wide;
	logic [DATA_WIDTH:0]   diff;
	logic                  take;
	logic [DATA_WIDTH-1:0] rem_next;
	logic [DATA_WIDTH-1:0] dq_next;
	rud_ctrl_t             ctrl_s1;
	logic [DATA_WIDTH-1:0] rem_s1;
	logic [DATA_WIDTH-1:0] dq_s1;
	logic [DATA_WIDTH-1:0] div_s1;

	// Shift in the next dividend bit and try subtracting the divisor.
	// The word dq holds unused dividend bits on top and new quotient bits below.
	always_comb begin
		wide     = {rem_in, dq_in[DATA_WIDTH-1]};
		diff     = wide - {1'b0, div_in};
		take     = ~diff[DATA_WIDTH];
		rem_next = take ? diff[DATA_WIDTH-1:0] : wide[DATA_WIDTH-1:0];
		dq_next  = {dq_in[DATA_WIDTH-2:0], take};
	end

	// Control register; only the valid flag needs a reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (advance) begin
			ctrl_s1 <= ctrl_in;
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s1 <= rem_next;
			dq_s1  <= dq_next;
			div_s1 <= div_in;
		end
	end

	assign ctrl_out = ctrl_s1;
	assign rem_out  = rem_s1;
	assign dq_out   = dq_s1;
	assign div_out  = div_s1;

endmodule

### rtl/core/restoring_unsigned_divider.sv
// Restoring unsigned divider: a chain of DATA_WIDTH cells, one quotient bit per cell.
// An accepted item steps through every cell's register in turn before its result is valid.
// Throughput is one item per cycle; the whole chain holds while a result waits.
// The last cell's register is the output register.
// Reset (arst_n, asynchronous) clears every valid flag; data registers are not reset.
// Depends on rud_pkg and rud_cell.
module restoring_unsigned_divider #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);
	import rud_pkg::*;

	rud_ctrl_t             ctrl_chain [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] rem_chain  [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] dq_chain   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] div_chain  [DATA_WIDTH+1];
	logic                  advance;
	rud_ctrl_t             last_ctrl;

	// The chain moves unless a finished item is waiting at the output.
	assign last_ctrl = ctrl_chain[DATA_WIDTH];
	assign advance   = ~last_ctrl.valid | out_ready;
	assign in_ready  = advance;

	// Feed the first cell; zero operands are flagged here.
	always_comb begin
		ctrl_chain[0].valid         = in_valid;
		ctrl_chain[0].dividend_zero = (dividend == '0);
		ctrl_chain[0].divisor_zero  = (divisor == '0);
		rem_chain[0]                = '0;
		dq_chain[0]                 = dividend;
		div_chain[0]                = divisor;
	end

	// Row of identical step cells.
	for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
		rud_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.ctrl_in  (ctrl_chain[g]),
			.rem_in   (rem_chain[g]),
			.dq_in    (dq_chain[g]),
			.div_in   (div_chain[g]),
			.ctrl_out (ctrl_chain[g+1]),
			.rem_out  (rem_chain[g+1]),
			.dq_out   (dq_chain[g+1]),
			.div_out  (div_chain[g+1])
		);
	end

	// Result select: zero dividend wins, then zero divisor gives all ones.
	always_comb begin
		out_valid = last_ctrl.valid;
		if (last_ctrl.dividend_zero) begin
			quotient  = '0;
			remainder = '0;
		end else if (last_ctrl.divisor_zero) begin
			quotient  = '1;
			remainder = '1;
		end else begin
			quotient  = dq_chain[DATA_WIDTH];
			remainder = rem_chain[DATA_WIDTH];
		end
	end

	// The last cell's divisor copy is not needed past the final step.
	logic unused_div;
	assign unused_div = ^div_chain[DATA_WIDTH];

endmodule

### rtl/core/rud_checker.sv
// Port-level checker for the restoring unsigned divider, bound to the top level.
// Depends on restoring_unsigned_divider_macros.svh.
`include "restoring_unsigned_divider_macros.svh"

module rud_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] quotient,
	input logic [DATA_WIDTH-1:0] remainder
);

	// A stalled result stays offered and unchanged.
	`RUD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`RUD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(quotient) && $stable(remainder))

	// With no result waiting, the divider takes a new item.
	`RUD_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// A result taken in this cycle frees the chain for a new item.
	`RUD_ASSERT_SAME(a_ready_on_drain, clk, arst_n, out_valid && out_ready, in_ready)

	// A real remainder is below the divisor, so all ones means a zero divisor.
	`RUD_ASSERT_SAME(a_rem_ones, clk, arst_n, out_valid && (remainder == '1), quotient == '1)

	logic unused_in_valid;
	assign unused_in_valid = in_valid;

endmodule

bind restoring_unsigned_divider rud_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_rud_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.quotient  (quotient),
	.remainder (remainder)
);

### dv/tb_restoring_unsigned_divider.sv
// Testbench for restoring_unsigned_divider: directed corner divisions, then random
// traffic under varying handshake stalls, checked against a bit-serial divide predictor.
// Depends only on the divider RTL.
`timescale 1ns / 100ps

module tb_restoring_unsigned_divider;

	localparam int DATA_WIDTH = 32;
	localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;
	localparam logic [DATA_WIDTH-1:0] TOP_BIT = 1 << (DATA_WIDTH - 1);
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 597;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] quotient;
		logic [DATA_WIDTH-1:0] remainder;
	} division_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [DATA_WIDTH-1:0] dividend = '0;
	logic [DATA_WIDTH-1:0] divisor = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [DATA_WIDTH-1:0] quotient;
	logic [DATA_WIDTH-1:0] remainder;

	division_result_t pending_results[$];
	int               error_count = 0;
	int               cycle_count = 0;
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;

	restoring_unsigned_divider #(
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.dividend (dividend),
		.divisor  (divisor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quotient (quotient),
		.remainder(remainder)
	);

	always #4 clk = ~clk;

	// Restoring division with a partial remainder one bit wider than the data.
	function automatic division_result_t predict_division(
		input logic [DATA_WIDTH-1:0] num,
		input logic [DATA_WIDTH-1:0] den
	);
		division_result_t res;
		logic [DATA_WIDTH:0] partial;
		partial = '0;
		res.quotient = '0;
		if (num == '0) begin
			res.remainder = '0;
		end else if (den == '0) begin
			res.quotient = ALL_ONES;
			res.remainder = ALL_ONES;
		end else begin
			for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
				partial = {partial[DATA_WIDTH-1:0], num[i]};
				if (partial >= {1'b0, den}) begin
					partial = partial - {1'b0, den};
					res.quotient[i] = 1'b1;
				end
			end
			res.remainder = partial[DATA_WIDTH-1:0];
		end
		return res;
	endfunction

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each accepted result with the oldest expected one.
	always @(posedge clk) begin
		division_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding: quotient %h remainder %h",
					quotient, remainder);
				error_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (quotient !== exp_res.quotient) begin
					$error("quotient: expected %h, actual %h", exp_res.quotient, quotient);
					error_count++;
				end
				if (remainder !== exp_res.remainder) begin
					$error("remainder: expected %h, actual %h", exp_res.remainder, remainder);
					error_count++;
				end
			end
		end
	end

	// Present one division, idling first at random, and record its expected result.
	task automatic send_division(input logic [DATA_WIDTH-1:0] num,
			input logic [DATA_WIDTH-1:0] den);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		dividend <= num;
		divisor <= den;
		do begin
			@(posedge clk);
		end while (!in_ready);
		pending_results.push_back(predict_division(num, den));
	endtask

	task automatic wait_results_drained();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// A random operand whose magnitude spans from a single bit to the full width.
	function automatic logic [DATA_WIDTH-1:0] random_operand();
		return $urandom >> $urandom_range(DATA_WIDTH - 1);
	endfunction

	// Zero operands, all-ones, divisors at and above the top bit, equal operands.
	task automatic test_corner_divisions();
		send_division('0, '0);
		send_division('0, 32'd5);
		send_division('0, ALL_ONES);
		send_division(32'd5, '0);
		send_division(ALL_ONES, '0);
		send_division(ALL_ONES, 32'd1);
		send_division(ALL_ONES, ALL_ONES);
		send_division(ALL_ONES, TOP_BIT);
		send_division(TOP_BIT - 1, TOP_BIT);
		send_division(TOP_BIT, TOP_BIT);
		send_division(ALL_ONES - 1, ALL_ONES);
		send_division(ALL_ONES, ALL_ONES - 1);
		send_division(32'd1, 32'd1);
		send_division(32'd1, ALL_ONES);
		send_division(32'd100, 32'd7);
		send_division(32'h1234_5678, 32'd1);
		send_division(32'hAAAA_AAAA, 32'h5555_5555);
		send_division(32'h5555_5555, 32'hAAAA_AAAA);
		send_division(32'h8000_0001, 32'hC000_0000);
		send_division(ALL_ONES, 32'd2);
		send_division(32'hDEAD_BEEF, 32'h10);
	endtask

	// Random divisions that favor the cases the restoring step treats differently.
	task automatic test_random_divisions(input int item_count);
		logic [DATA_WIDTH-1:0] num;
		logic [DATA_WIDTH-1:0] den;
		for (int i = 0; i < item_count; i++) begin
			num = $urandom;
			den = $urandom;
			case ($urandom_range(9))
				0: den = '0;
				1: num = '0;
				2: den = $urandom | TOP_BIT;
				3: begin
					num = $urandom | TOP_BIT;
					den = num - $urandom_range(3);
				end
				4: den = num;
				5: den = $urandom_range(15);
				6: begin
					num = random_operand();
					den = random_operand();
				end
				7: den = random_operand();
				default: ;
			endcase
			send_division(num, den);
		end
	endtask

	// Let the pipeline empty completely in the middle of traffic, then resume.
	task automatic test_pause_until_drained();
		test_random_divisions(20);
		in_valid <= 1'b0;
		wait_results_drained();
		test_random_divisions(20);
	endtask

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_divisions();
		test_pause_until_drained();

		// Sender mostly busy, receiver mostly stalled.
		send_idle_pct = 9;
		recv_idle_pct = 80;
		test_random_divisions(ITEMS_PER_PHASE);

		// Sender mostly idle, receiver mostly ready.
		send_idle_pct = 80;
		recv_idle_pct = 9;
		test_random_divisions(ITEMS_PER_PHASE);

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_divisions(ITEMS_PER_PHASE);

		in_valid <= 1'b0;
		wait_results_drained();
		repeat (DATA_WIDTH + 8) @(posedge clk);

		if (error_count == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
